>>> hw/rtl/srst_pkg.sv
// Types and constants of the setpoint ramp with safety trip block.
// No dependencies; compiled first.
package srst_pkg;

	localparam int POS_W   = 32;
	localparam int MAG_W   = 31;
	localparam int TICKS_W = 16;
	localparam int DELTA_W = 19;
	localparam int KP_W    = 21;
	localparam int KD_W    = 18;
	localparam int CNT_W   = 17;
	localparam int SENT_W  = 32;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 32;

	// divider operand widths: |delta| fits 18 bits, quotient < |delta|
	localparam int DMAG_W    = 18;
	localparam int DIV_STEPS = DMAG_W;
	localparam int DSTEP_W   = 5;

	localparam logic [DELTA_W-1:0] Q_THREE  = DELTA_W'(196608);
	localparam logic [KP_W-1:0]    Q_KP_CAP = KP_W'(1966080);
	localparam logic [KD_W-1:0]    Q_KD_CAP = KD_W'(196608);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_RAMP = 3'd1,
		PH_HOLD = 3'd2,
		PH_TAIL = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		TRIP_NONE   = 2'd0,
		TRIP_SPEED  = 2'd1,
		TRIP_TORQUE = 2'd2
	} trip_t;

	typedef enum logic [CFG_IW-1:0] {
		REG_RAMP_TICKS   = 3'd0,
		REG_HOLD_TICKS   = 3'd1,
		REG_MOVE_DELTA   = 3'd2,
		REG_GAIN_KP      = 3'd3,
		REG_GAIN_KD      = 3'd4,
		REG_SPEED_LIMIT  = 3'd5,
		REG_TORQUE_LIMIT = 3'd6,
		REG_TAIL_KD      = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} seq_t;

	typedef struct packed {
		logic               start;
		logic [DMAG_W-1:0]  mag;
		logic [TICKS_W-1:0] k;
		logic [TICKS_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DMAG_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> hw/rtl/srst_if.sv
// Channel interfaces: measurement items in, command items out, config writes.
// Depends on srst_pkg.
interface srst_meas_if;
	import srst_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    start_req;
	logic                    stop_request;
	logic signed [POS_W-1:0] meas_pos;
	logic signed [POS_W-1:0] meas_vel;
	logic signed [POS_W-1:0] meas_torque;

	modport source (output valid, start_req, stop_request, meas_pos, meas_vel, meas_torque,
		input ready);
	modport sink (input valid, start_req, stop_request, meas_pos, meas_vel, meas_torque,
		output ready);
endinterface

interface srst_cmd_if;
	import srst_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] cmd_pos;
	logic [KP_W-1:0]         cmd_kp;
	logic [KD_W-1:0]         cmd_kd;
	logic [2:0]              phase;
	logic [1:0]              trip_cause;
	logic [MAG_W-1:0]        peak_speed;
	logic [MAG_W-1:0]        peak_torque;
	logic [SENT_W-1:0]       sent_count;

	modport source (output valid, cmd_pos, cmd_kp, cmd_kd, phase, trip_cause, peak_speed,
		peak_torque, sent_count, input ready);
	modport sink (input valid, cmd_pos, cmd_kp, cmd_kd, phase, trip_cause, peak_speed,
		peak_torque, sent_count, output ready);
endinterface

interface srst_cfg_if;
	import srst_pkg::*;
	logic              valid;
	logic              ready;
	logic [CFG_IW-1:0] index;
	logic [CFG_DW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/srst_div.sv
// Shared multiply then restoring divide: quot = (mag * k) / den, one bit a cycle.
// Depends on srst_pkg. Requires mag*k/den < 2^DMAG_W.
module srst_div (
	input  logic              clk,
	input  logic              arst_n,
	input  srst_pkg::div_req_t req,
	output srst_pkg::div_rsp_t rsp
);
	import srst_pkg::*;

	logic [DMAG_W+TICKS_W-1:0] prod;
	logic [TICKS_W-1:0]        rem_q;
	logic [DMAG_W-1:0]         low_q;
	logic [TICKS_W-1:0]        den_q;
	logic [DSTEP_W-1:0]        cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [TICKS_W:0]          trial;
	logic [TICKS_W:0]          diff;
	logic                      ge;

	assign prod  = req.mag * req.k;
	assign trial = {rem_q, low_q[DMAG_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DSTEP_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DSTEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= prod[DMAG_W+TICKS_W-1:DMAG_W];
			low_q <= prod[DMAG_W-1:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TICKS_W-1:0] : trial[TICKS_W-1:0];
			low_q <= {low_q[DMAG_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = low_q;

endmodule

>>> hw/rtl/setpoint_ramp_with_safety_trip_top.sv
// Top level: ramp/hold/tail sequencer, trip checks, config registers, output register.
// Depends on srst_pkg, srst_if, srst_div.
//
// channel  dir  handshake     payload
// meas     in   valid/ready   start_req, stop_request, meas_pos, meas_vel, meas_torque
// cmd      out  valid/ready   cmd_pos, cmd_kp, cmd_kd, phase, trip_cause, peaks, sent_count
// cfg      in   valid/ready   index, data (always ready)
//
// One item per control tick. A tick that needs a ramp fraction steps through accept,
// 18 divider steps (one quotient bit each), done, output load; others skip the divide.
// meas.ready is high only while the sequencer is idle; the finished item sits in the
// output register, so a stalled cmd channel holds only the next item's last step.
// arst_n clears state and restores register defaults.
module setpoint_ramp_with_safety_trip_top #(
	parameter int TAIL_TICKS = 150
) (
	input logic          clk,
	input logic          arst_n,
	srst_meas_if.sink    meas,
	srst_cmd_if.source   cmd,
	srst_cfg_if.sink     cfg
);
	import srst_pkg::*;

	localparam int TAIL_W = $clog2(TAIL_TICKS + 1);

	function automatic logic [MAG_W-1:0] mag31(input logic signed [POS_W-1:0] v);
		logic [POS_W-1:0] a;
		a = v[POS_W-1] ? (~v + 1'b1) : v;
		return a[POS_W-1] ? {MAG_W{1'b1}} : a[MAG_W-1:0];
	endfunction

	// configuration
	logic [TICKS_W-1:0]        ramp_ticks_q;
	logic [TICKS_W-1:0]        hold_ticks_q;
	logic signed [DELTA_W-1:0] move_delta_q;
	logic [KP_W-1:0]           gain_kp_q;
	logic [KD_W-1:0]           gain_kd_q;
	logic [MAG_W-1:0]          speed_limit_q;
	logic [MAG_W-1:0]          torque_limit_q;
	logic [KD_W-1:0]           tail_kd_q;

	// run state
	phase_t                  ph_q, ph_n;
	logic signed [POS_W-1:0] start_q, start_n;
	logic [CNT_W-1:0]        tick_q, tick_n;
	logic [TAIL_W-1:0]       tail_q, tail_n;
	logic [MAG_W-1:0]        pks_q, pks_n;
	logic [MAG_W-1:0]        pkt_q, pkt_n;
	trip_t                   trip_q, trip_n;
	logic [SENT_W-1:0]       sent_q, sent_n;
	logic                    emit;
	logic [KP_W-1:0]         kp_n;
	logic [KD_W-1:0]         kd_n;

	// item in flight
	seq_t                      state_q, state_n;
	logic                      emit_q;
	logic                      neg_q;
	logic signed [DELTA_W-1:0] off_q;
	logic [KP_W-1:0]           kp_q;
	logic [KD_W-1:0]           kd_q;
	logic                      out_valid_q;

	logic                      accept;
	logic                      need_div;
	logic                      load_out;
	logic [MAG_W-1:0]          vmag, tmag;
	logic [CNT_W-1:0]          span;
	logic [DMAG_W-1:0]         delta_mag;
	logic [DELTA_W-1:0]        delta_abs;
	logic signed [POS_W:0]     pos_sum;
	logic signed [POS_W-1:0]   pos_sat;
	logic signed [DELTA_W-1:0] cfg_delta;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign meas.ready = (state_q == ST_IDLE);
	assign accept     = meas.valid && meas.ready;
	assign cfg.ready  = 1'b1;

	assign vmag      = mag31(meas.meas_vel);
	assign tmag      = mag31(meas.meas_torque);
	assign span      = {1'b0, ramp_ticks_q} + {1'b0, hold_ticks_q};
	assign delta_abs = move_delta_q[DELTA_W-1] ? (~move_delta_q + 1'b1) : move_delta_q;
	assign delta_mag = delta_abs[DMAG_W-1:0];
	assign need_div  = emit && (tick_n < {1'b0, ramp_ticks_q});

	always_comb begin
		ph_n    = ph_q;
		start_n = start_q;
		tick_n  = tick_q;
		tail_n  = tail_q;
		pks_n   = pks_q;
		pkt_n   = pkt_q;
		trip_n  = trip_q;
		sent_n  = sent_q;
		emit    = 1'b0;
		kp_n    = '0;
		kd_n    = '0;
		if (meas.start_req) begin
			start_n = meas.meas_pos;
			tick_n  = '0;
			tail_n  = '0;
			pks_n   = '0;
			pkt_n   = '0;
			trip_n  = TRIP_NONE;
			sent_n  = '0;
			emit    = 1'b1;
		end else if (ph_q == PH_RAMP || ph_q == PH_HOLD) begin
			if (vmag > pks_q) pks_n = vmag;
			if (tmag > pkt_q) pkt_n = tmag;
			if (vmag > speed_limit_q) begin
				trip_n = TRIP_SPEED;
				ph_n   = PH_DONE;
			end else if (tmag > torque_limit_q) begin
				trip_n = TRIP_TORQUE;
				ph_n   = PH_DONE;
			end else if (meas.stop_request) begin
				ph_n   = PH_TAIL;
				tail_n = '0;
			end else begin
				tick_n = tick_q + 1'b1;
				if (tick_n > span) begin
					ph_n   = PH_TAIL;
					tail_n = '0;
				end else begin
					emit = 1'b1;
				end
			end
		end else if (ph_q == PH_TAIL) begin
			if (tail_q >= TAIL_W'(TAIL_TICKS)) ph_n = PH_DONE;
		end else if (ph_q != PH_DONE) begin
			ph_n = PH_IDLE;
		end

		if (emit) begin
			ph_n = (tick_n < {1'b0, ramp_ticks_q}) ? PH_RAMP : PH_HOLD;
			kp_n = gain_kp_q;
			kd_n = gain_kd_q;
			if (sent_n != {SENT_W{1'b1}}) sent_n = sent_n + 1'b1;
		end else if (ph_n == PH_TAIL) begin
			kd_n   = tail_kd_q;
			tail_n = tail_n + 1'b1;
		end
	end

	assign div_req.start = accept && need_div;
	assign div_req.mag   = delta_mag;
	assign div_req.k     = tick_n[TICKS_W-1:0];
	assign div_req.den   = ramp_ticks_q;

	srst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign pos_sum = {start_q[POS_W-1], start_q} + (POS_W+1)'(off_q);
	always_comb begin
		if (pos_sum[POS_W] != pos_sum[POS_W-1])
			pos_sat = pos_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		else
			pos_sat = pos_sum[POS_W-1:0];
	end

	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || cmd.ready);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_n = need_div ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				if (div_rsp.done) state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (load_out) state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			ph_q        <= PH_IDLE;
			start_q     <= '0;
			tick_q      <= '0;
			tail_q      <= '0;
			pks_q       <= '0;
			pkt_q       <= '0;
			trip_q      <= TRIP_NONE;
			sent_q      <= '0;
		end else begin
			state_q <= state_n;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (cmd.ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				ph_q    <= ph_n;
				start_q <= start_n;
				tick_q  <= tick_n;
				tail_q  <= tail_n;
				pks_q   <= pks_n;
				pkt_q   <= pkt_n;
				trip_q  <= trip_n;
				sent_q  <= sent_n;
			end
		end
	end

	// item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_q <= emit;
			neg_q  <= move_delta_q[DELTA_W-1];
			off_q  <= move_delta_q;
			kp_q   <= kp_n;
			kd_q   <= kd_n;
		end else if (state_q == ST_DIV && div_rsp.done) begin
			off_q <= neg_q ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cmd.cmd_pos     <= emit_q ? pos_sat : '0;
			cmd.cmd_kp      <= kp_q;
			cmd.cmd_kd      <= kd_q;
			cmd.phase       <= ph_q;
			cmd.trip_cause  <= trip_q;
			cmd.peak_speed  <= pks_q;
			cmd.peak_torque <= pkt_q;
			cmd.sent_count  <= sent_q;
		end
	end

	assign cmd.valid = out_valid_q;

	// configuration writes, with range clamps
	assign cfg_delta = $signed(cfg.data[DELTA_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_ticks_q   <= TICKS_W'(1000);
			hold_ticks_q   <= TICKS_W'(1000);
			move_delta_q   <= DELTA_W'(32768);
			gain_kp_q      <= KP_W'(524288);
			gain_kd_q      <= KD_W'(32768);
			speed_limit_q  <= MAG_W'(196608);
			torque_limit_q <= MAG_W'(327680);
			tail_kd_q      <= KD_W'(196608);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_RAMP_TICKS:   ramp_ticks_q <= cfg.data[TICKS_W-1:0];
				REG_HOLD_TICKS:   hold_ticks_q <= cfg.data[TICKS_W-1:0];
				REG_MOVE_DELTA: begin
					if (cfg_delta > $signed(Q_THREE))
						move_delta_q <= Q_THREE;
					else if (cfg_delta < -$signed(Q_THREE))
						move_delta_q <= -$signed(Q_THREE);
					else
						move_delta_q <= cfg_delta;
				end
				REG_GAIN_KP: begin
					gain_kp_q <= (cfg.data[KP_W-1:0] > Q_KP_CAP) ? Q_KP_CAP
						: cfg.data[KP_W-1:0];
				end
				REG_GAIN_KD: begin
					gain_kd_q <= (cfg.data[KD_W-1:0] > Q_KD_CAP) ? Q_KD_CAP
						: cfg.data[KD_W-1:0];
				end
				REG_SPEED_LIMIT:  speed_limit_q  <= cfg.data[MAG_W-1:0];
				REG_TORQUE_LIMIT: torque_limit_q <= cfg.data[MAG_W-1:0];
				REG_TAIL_KD: begin
					tail_kd_q <= (cfg.data[KD_W-1:0] > Q_KD_CAP) ? Q_KD_CAP
						: cfg.data[KD_W-1:0];
				end
				default: ;
			endcase
		end
	end

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide step");

	a_trip_done: assert property (@(posedge clk) disable iff (!arst_n)
		trip_q != TRIP_NONE |-> ph_q == PH_DONE)
		else $error("trip recorded without done phase");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= TAIL_W'(TAIL_TICKS))
		else $error("tail count past its end");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> cmd.valid && state_q == ST_IDLE)
		else $error("finished item not presented");

endmodule

>>> tb/srst_cmd_check.sv
`timescale 1ns / 1ps
// Command checker for the setpoint ramp block: mirrors the config writes, predicts
// each command item from the accepted measurement items and compares it with the output.
// Depends on srst_pkg and srst_if.
module srst_cmd_check
	import srst_pkg::*;
#(
	parameter int TAIL_TICKS = 150
) (
	input  logic clk,
	input  logic arst_n,
	srst_meas_if meas,
	srst_cmd_if  cmd,
	srst_cfg_if  cfg,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic [KP_W-1:0]         kp;
		logic [KD_W-1:0]         kd;
		logic [2:0]              ph;
		logic [1:0]              trip;
		logic [MAG_W-1:0]        pk_speed;
		logic [MAG_W-1:0]        pk_torque;
		logic [SENT_W-1:0]       sent;
	} cmd_item_t;

	// register copies
	logic [TICKS_W-1:0]        ramp_len, hold_len;
	logic signed [DELTA_W-1:0] delta;
	logic [KP_W-1:0]           kp_set;
	logic [KD_W-1:0]           kd_set, tail_kd_set;
	logic [MAG_W-1:0]          spd_lim, trq_lim;

	// sequencer copy
	phase_t                  run_ph;
	logic signed [POS_W-1:0] start_p;
	logic [CNT_W-1:0]        tick_k;
	logic [7:0]              tail_n;
	logic [MAG_W-1:0]        pk_spd, pk_trq;
	trip_t                   trip_st;
	logic [SENT_W-1:0]       sent_n;

	cmd_item_t pending_cmds[$];
	int        errors = 0;
	int        queued = 0;

	assign fail_count = errors;
	assign pending    = queued;

	function automatic void reset_model();
		ramp_len    = 16'd1000;
		hold_len    = 16'd1000;
		delta       = DELTA_W'(32768);
		kp_set      = KP_W'(524288);
		kd_set      = KD_W'(32768);
		spd_lim     = MAG_W'(196608);
		trq_lim     = MAG_W'(327680);
		tail_kd_set = KD_W'(196608);
		run_ph      = PH_IDLE;
		start_p     = '0;
		tick_k      = '0;
		tail_n      = '0;
		pk_spd      = '0;
		pk_trq      = '0;
		trip_st     = TRIP_NONE;
		sent_n      = '0;
	endfunction

	function automatic void write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		int d;
		d = int'($signed(data[DELTA_W-1:0]));
		case (cfg_reg_t'(idx))
			REG_RAMP_TICKS:   ramp_len = data[TICKS_W-1:0];
			REG_HOLD_TICKS:   hold_len = data[TICKS_W-1:0];
			REG_MOVE_DELTA: begin
				if (d > int'(Q_THREE))
					d = int'(Q_THREE);
				if (d < -int'(Q_THREE))
					d = -int'(Q_THREE);
				delta = DELTA_W'(d);
			end
			REG_GAIN_KP:      kp_set = (data[KP_W-1:0] > Q_KP_CAP) ? Q_KP_CAP : data[KP_W-1:0];
			REG_GAIN_KD:      kd_set = (data[KD_W-1:0] > Q_KD_CAP) ? Q_KD_CAP : data[KD_W-1:0];
			REG_SPEED_LIMIT:  spd_lim = data[MAG_W-1:0];
			REG_TORQUE_LIMIT: trq_lim = data[MAG_W-1:0];
			REG_TAIL_KD:      tail_kd_set = (data[KD_W-1:0] > Q_KD_CAP) ? Q_KD_CAP :
				data[KD_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [MAG_W-1:0] mag_sat(logic signed [POS_W-1:0] v);
		longint a;
		a = v;
		if (a < 0)
			a = -a;
		return (a > longint'(32'h7FFF_FFFF)) ? '1 : a[MAG_W-1:0];
	endfunction

	function automatic logic signed [POS_W-1:0] ramp_point(logic [CNT_W-1:0] k);
		longint d, m, p;
		d = delta;
		p = start_p;
		if (k >= ramp_len) begin
			p = p + d;
		end else begin
			m = ((d < 0) ? -d : d) * longint'(k) / longint'(ramp_len);
			p = p + ((d < 0) ? -m : m);
		end
		if (p > longint'(32'sh7FFF_FFFF))
			p = 32'sh7FFF_FFFF;
		if (p < -longint'(64'h8000_0000))
			p = -longint'(64'h8000_0000);
		return p[POS_W-1:0];
	endfunction

	function automatic cmd_item_t next_command(logic start, logic stop,
		logic signed [POS_W-1:0] pos, logic signed [POS_W-1:0] vel,
		logic signed [POS_W-1:0] trq);
		cmd_item_t        c;
		logic             emit;
		logic [MAG_W-1:0] v, t;
		c    = '0;
		emit = 1'b0;
		if (start) begin
			start_p = pos;
			tick_k  = '0;
			tail_n  = '0;
			pk_spd  = '0;
			pk_trq  = '0;
			trip_st = TRIP_NONE;
			sent_n  = '0;
			emit    = 1'b1;
		end else if (run_ph == PH_RAMP || run_ph == PH_HOLD) begin
			v = mag_sat(vel);
			t = mag_sat(trq);
			if (v > pk_spd)
				pk_spd = v;
			if (t > pk_trq)
				pk_trq = t;
			if (v > spd_lim) begin
				trip_st = TRIP_SPEED;
				run_ph  = PH_DONE;
			end else if (t > trq_lim) begin
				trip_st = TRIP_TORQUE;
				run_ph  = PH_DONE;
			end else if (stop) begin
				run_ph = PH_TAIL;
				tail_n = '0;
			end else begin
				tick_k = tick_k + 1'b1;
				if (tick_k > CNT_W'(ramp_len) + CNT_W'(hold_len)) begin
					run_ph = PH_TAIL;
					tail_n = '0;
				end else begin
					emit = 1'b1;
				end
			end
		end else if (run_ph == PH_TAIL) begin
			if (tail_n >= TAIL_TICKS)
				run_ph = PH_DONE;
		end else if (run_ph != PH_DONE) begin
			run_ph = PH_IDLE;
		end

		if (emit) begin
			run_ph = (tick_k < ramp_len) ? PH_RAMP : PH_HOLD;
			c.pos  = ramp_point(tick_k);
			c.kp   = kp_set;
			c.kd   = kd_set;
			if (sent_n != '1)
				sent_n = sent_n + 1'b1;
		end else if (run_ph == PH_TAIL) begin
			c.kd   = tail_kd_set;
			tail_n = tail_n + 1'b1;
		end
		c.ph        = run_ph;
		c.trip      = trip_st;
		c.pk_speed  = pk_spd;
		c.pk_torque = pk_trq;
		c.sent      = sent_n;
		return c;
	endfunction

	function automatic string show(cmd_item_t c);
		return $sformatf("pos=%h kp=%h kd=%h phase=%0d trip=%0d pk_spd=%h pk_trq=%h sent=%0d",
			c.pos, c.kp, c.kd, c.ph, c.trip, c.pk_speed, c.pk_torque, c.sent);
	endfunction

	initial reset_model();

	always @(posedge clk or negedge arst_n) begin
		cmd_item_t got, want;
		if (!arst_n) begin
			reset_model();
			pending_cmds.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				write_cfg(cfg.index, cfg.data);
			if (cmd.valid && cmd.ready) begin
				got.pos       = cmd.cmd_pos;
				got.kp        = cmd.cmd_kp;
				got.kd        = cmd.cmd_kd;
				got.ph        = cmd.phase;
				got.trip      = cmd.trip_cause;
				got.pk_speed  = cmd.peak_speed;
				got.pk_torque = cmd.peak_torque;
				got.sent      = cmd.sent_count;
				if (pending_cmds.size() == 0) begin
					if (errors < 10)
						$display("%t unexpected command item: %s", $realtime, show(got));
					errors++;
				end else begin
					want = pending_cmds.pop_front();
					if (got !== want) begin
						if (errors < 10) begin
							$display("%t command mismatch", $realtime);
							$display("  want %s", show(want));
							$display("  got  %s", show(got));
						end
						errors++;
					end
				end
			end
			if (meas.valid && meas.ready)
				pending_cmds.push_back(next_command(meas.start_req, meas.stop_request,
					meas.meas_pos, meas.meas_vel, meas.meas_torque));
		end
		queued = pending_cmds.size();
	end

endmodule

>>> tb/tb_setpoint_ramp_with_safety_trip_top.sv
`timescale 1ns / 1ps
// Testbench top for the setpoint ramp block: clock, reset, measurement and config
// stimulus, command back-pressure and verdict. Depends on srst_pkg, srst_if, srst_cmd_check.
module tb_setpoint_ramp_with_safety_trip_top;
	import srst_pkg::*;

	localparam int TAIL_LEN   = 150;
	localparam int LONG_STALL = 600;
	localparam int SETTLE     = 40;
	localparam int LIMIT_NS   = 15_000_000;

	logic clk;
	logic arst_n;

	srst_meas_if meas();
	srst_cmd_if  cmd();
	srst_cfg_if  cfg();

	int fail_count, pending;
	bit calm       = 1'b0;
	bit long_stall = 1'b0;
	int counted    = 0;
	int quota_end  = 0;

	logic [TICKS_W-1:0] cur_ramp, cur_hold;
	logic [MAG_W-1:0]   cur_spd, cur_trq;

	setpoint_ramp_with_safety_trip_top #(.TAIL_TICKS(TAIL_LEN)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.meas  (meas),
		.cmd   (cmd),
		.cfg   (cfg)
	);

	srst_cmd_check #(.TAIL_TICKS(TAIL_LEN)) cmd_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.meas      (meas),
		.cmd       (cmd),
		.cfg       (cfg),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// command side back-pressure
	initial begin : rx_drive
		int n;
		cmd.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (long_stall) begin
				cmd.ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall = 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				cmd.ready <= 1'b0;
				n = $urandom_range(1, 17);
				repeat (n) @(negedge clk);
			end else begin
				cmd.ready <= 1'b1;
				n = $urandom_range(1, 24);
				repeat (n) @(negedge clk);
			end
		end
	end

	task automatic send_tick(logic start, logic stop, logic [31:0] pos, logic [31:0] vel,
		logic [31:0] trq);
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			meas.valid <= 1'b0;
			n = $urandom_range(1, 17);
			repeat (n) @(negedge clk);
		end
		meas.valid        <= 1'b1;
		meas.start_req    <= start;
		meas.stop_request <= stop;
		meas.meas_pos     <= pos;
		meas.meas_vel     <= vel;
		meas.meas_torque  <= trq;
		do @(posedge clk); while (!meas.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
	endtask

	task automatic load_setting(logic [31:0] ramp_d, logic [31:0] hold_d, logic [31:0] delta_d,
		logic [31:0] kp_d, logic [31:0] kd_d, logic [31:0] spd_d, logic [31:0] trq_d,
		logic [31:0] tkd_d);
		write_reg(REG_RAMP_TICKS, ramp_d);
		write_reg(REG_HOLD_TICKS, hold_d);
		write_reg(REG_MOVE_DELTA, delta_d);
		write_reg(REG_GAIN_KP, kp_d);
		write_reg(REG_GAIN_KD, kd_d);
		write_reg(REG_SPEED_LIMIT, spd_d);
		write_reg(REG_TORQUE_LIMIT, trq_d);
		write_reg(REG_TAIL_KD, tkd_d);
		cfg.valid <= 1'b0;
		cur_ramp = ramp_d[TICKS_W-1:0];
		cur_hold = hold_d[TICKS_W-1:0];
		cur_spd  = spd_d[MAG_W-1:0];
		cur_trq  = trq_d[MAG_W-1:0];
	endtask

	task automatic load_random_setting();
		load_setting({16'($urandom), 16'($urandom_range(1, 24))},
			{16'($urandom), 16'($urandom_range(0, 24))},
			$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic drain();
		meas.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// signed value with magnitude at or below lim
	function automatic logic [31:0] under_lim(logic [MAG_W-1:0] lim);
		logic [31:0] m;
		m = ($urandom_range(0, 7) == 0) ? 32'(lim) : $urandom_range(0, 32'(lim));
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// signed value with magnitude above lim, else (lim all ones, or one in ten) 0x80000000 or random
	function automatic logic [31:0] beyond(logic [MAG_W-1:0] lim);
		logic [31:0] m;
		if (lim == '1 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 32'h8000_0000 : $urandom;
		m = $urandom_range(32'(lim) + 1, 32'h7FFF_FFFF);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	task automatic noise_ticks(int n);
		int i;
		for (i = 0; i < n && counted < quota_end; i++) begin
			send_tick(1'($urandom_range(0, 39) == 0), 1'($urandom), $urandom, $urandom,
				$urandom);
			counted++;
		end
	endtask

	// start tick, mostly in-limit ticks, then trip, stop, schedule end or interruption
	task automatic random_run();
		int          span, run_len, kind, i;
		logic [31:0] v, t;
		logic        stp;
		span = int'(cur_ramp) + int'(cur_hold) + 2;
		if (span > 40)
			span = 40;
		run_len = $urandom_range(0, span);
		send_tick(1'b1, 1'($urandom), $urandom, $urandom, $urandom);
		counted++;
		for (i = 0; i < run_len; i++) begin
			kind = $urandom_range(0, 99);
			v    = under_lim(cur_spd);
			t    = under_lim(cur_trq);
			stp  = 1'b0;
			if (kind < 2) begin
				v = beyond(cur_spd);
			end else if (kind < 4) begin
				t = beyond(cur_trq);
			end else if (kind < 5) begin
				v = beyond(cur_spd);
				t = beyond(cur_trq);
			end else if (kind < 8) begin
				stp = 1'b1;
			end
			send_tick(1'b0, stp, $urandom, v, t);
			counted++;
			if (kind < 8)
				break;
		end
		kind = $urandom_range(0, 9);
		if (kind < 2)
			noise_ticks($urandom_range(TAIL_LEN, TAIL_LEN + 6));
		else if (kind < 6)
			noise_ticks($urandom_range(0, 8));
	endtask

	task automatic run_items(int quota);
		quota_end = counted + quota;
		while (counted < quota_end)
			random_run();
	endtask

	initial begin
		arst_n            = 1'b0;
		meas.valid        = 1'b0;
		meas.start_req    = 1'b0;
		meas.stop_request = 1'b0;
		meas.meas_pos     = '0;
		meas.meas_vel     = '0;
		meas.meas_torque  = '0;
		cfg.valid         = 1'b0;
		cfg.index         = '0;
		cfg.data          = '0;
		cur_ramp          = 16'd1000;
		cur_hold          = 16'd1000;
		cur_spd           = MAG_W'(196608);
		cur_trq           = MAG_W'(327680);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (4) @(negedge clk);

		// reset register values, idle tick ignored
		send_tick(1'b0, 1'b0, 32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000);
		send_tick(1'b1, 1'b0, 32'h0001_0000, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, 32'h0000_1000, 32'hFFFF_F000);
		send_tick(1'b0, 1'b0, 32'h0, 32'hFFFF_0000, 32'h0001_0000);
		drain();

		// over-range gains and delta clamp, position saturates high, peaks saturate
		load_setting(32'd3, 32'd1, 32'h0003_FFFF, 32'h001F_FFFF, 32'h0003_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0003_FFFF);
		send_tick(1'b1, 1'b1, 32'h7FFF_FFF0, 32'h8000_0000, 32'h8000_0000);
		send_tick(1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		send_tick(1'b0, 1'b0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_tick(1'b0, 1'b0, 32'h0, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, 32'h0, 32'h0);
		send_tick(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// zero ramp length, negative clamp, saturates low, limit edges and trips
		load_setting(32'd0, 32'd2, 32'h0004_0000, 32'h0, 32'h0, 32'd100, 32'd200, 32'h0);
		send_tick(1'b1, 1'b0, 32'h8000_0005, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, 32'd100, -32'd200);
		send_tick(1'b0, 1'b1, 32'h0, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_tick(1'b1, 1'b0, 32'h0, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, 32'd101, 32'd201);
		send_tick(1'b0, 1'b1, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0F0F_F0F0);
		send_tick(1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0);
		send_tick(1'b0, 1'b0, 32'h0, -32'd100, -32'd201);
		drain();

		load_setting(32'd8, 32'd4, 32'd196608, 32'h001E_0000, 32'h0003_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
		run_items(150);
		drain();

		load_setting(32'd1, 32'd0, 32'hFFFD_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0003_0000);
		run_items(100);
		drain();

		load_setting(32'd0, 32'd10, $urandom, $urandom, $urandom, 32'h0004_0000,
			32'h0005_0000, $urandom);
		run_items(120);
		drain();

		load_setting(32'h0000_FFFF, 32'h0000_FFFF, 32'h0002_FFFF, 32'h0008_0000,
			32'h0000_8000, 32'h0003_0000, 32'h0005_0000, 32'h0001_0000);
		run_items(150);
		drain();

		load_random_setting();
		run_items(40);
		long_stall = 1'b1;
		run_items(150);
		drain();

		load_random_setting();
		run_items(190);
		drain();

		calm = 1'b1;
		load_random_setting();
		run_items(190);
		drain();

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
